FILE: rtl/core/dpsc_pkg.sv
// ----------------------------------------------------------------------------
// dpsc_pkg
// Shared widths, calibration fit constants and the configuration bundle for
// the distance pair steering controller.
// ----------------------------------------------------------------------------
package dpsc_pkg;

    localparam int READING_W = 12;
    localparam int DIST_W    = 16;
    localparam int STEER_W   = 12;
    localparam int GAIN_W    = 8;
    localparam int BYTE_W    = 8;

    // calibration arithmetic widths
    localparam int COEF_W  = 26;
    localparam int RATIO_W = 32;
    localparam int POW_W   = 33;
    localparam int TERM_W  = 19;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] FRAME_SYNC = 8'hA3;
    localparam logic [BYTE_W-1:0] FRAME_LEN  = 8'h04;
    localparam logic [BYTE_W-1:0] FRAME_CMD  = 8'h01;

    localparam logic [63:0] ONE_Q32 = 64'd4294967296;
    localparam logic [POW_W-1:0] POW_ONE = ONE_Q32[POW_W-1:0];

    // left fit, first exponential: 638.6 * exp(-0.004488 x)
    localparam logic [63:0] LA_NUM = 64'd4488;
    localparam logic [63:0] LA_DEN = 64'd1000000;
    localparam logic [63:0] LA_T1 = (ONE_Q32 * LA_NUM) / (LA_DEN * 64'd1);
    localparam logic [63:0] LA_T2 = (LA_T1 * LA_NUM) / (LA_DEN * 64'd2);
    localparam logic [63:0] LA_T3 = (LA_T2 * LA_NUM) / (LA_DEN * 64'd3);
    localparam logic [63:0] LA_T4 = (LA_T3 * LA_NUM) / (LA_DEN * 64'd4);
    localparam logic [63:0] LA_T5 = (LA_T4 * LA_NUM) / (LA_DEN * 64'd5);
    localparam logic [63:0] LA_T6 = (LA_T5 * LA_NUM) / (LA_DEN * 64'd6);
    localparam logic [63:0] LA_R =
        ONE_Q32 - LA_T1 + LA_T2 - LA_T3 + LA_T4 - LA_T5 + LA_T6;
    localparam logic [63:0] LA_C = (64'd6386 * 64'd65536 + 64'd10 / 64'd2) / 64'd10;

    // left fit, second exponential: 26.45 * exp(-0.000508 x)
    localparam logic [63:0] LB_NUM = 64'd508;
    localparam logic [63:0] LB_DEN = 64'd1000000;
    localparam logic [63:0] LB_T1 = (ONE_Q32 * LB_NUM) / (LB_DEN * 64'd1);
    localparam logic [63:0] LB_T2 = (LB_T1 * LB_NUM) / (LB_DEN * 64'd2);
    localparam logic [63:0] LB_T3 = (LB_T2 * LB_NUM) / (LB_DEN * 64'd3);
    localparam logic [63:0] LB_T4 = (LB_T3 * LB_NUM) / (LB_DEN * 64'd4);
    localparam logic [63:0] LB_T5 = (LB_T4 * LB_NUM) / (LB_DEN * 64'd5);
    localparam logic [63:0] LB_T6 = (LB_T5 * LB_NUM) / (LB_DEN * 64'd6);
    localparam logic [63:0] LB_R =
        ONE_Q32 - LB_T1 + LB_T2 - LB_T3 + LB_T4 - LB_T5 + LB_T6;
    localparam logic [63:0] LB_C = (64'd2645 * 64'd65536 + 64'd100 / 64'd2) / 64'd100;

    // right fit, first exponential: 52.04 * exp(-0.001964 x)
    localparam logic [63:0] RA_NUM = 64'd1964;
    localparam logic [63:0] RA_DEN = 64'd1000000;
    localparam logic [63:0] RA_T1 = (ONE_Q32 * RA_NUM) / (RA_DEN * 64'd1);
    localparam logic [63:0] RA_T2 = (RA_T1 * RA_NUM) / (RA_DEN * 64'd2);
    localparam logic [63:0] RA_T3 = (RA_T2 * RA_NUM) / (RA_DEN * 64'd3);
    localparam logic [63:0] RA_T4 = (RA_T3 * RA_NUM) / (RA_DEN * 64'd4);
    localparam logic [63:0] RA_T5 = (RA_T4 * RA_NUM) / (RA_DEN * 64'd5);
    localparam logic [63:0] RA_T6 = (RA_T5 * RA_NUM) / (RA_DEN * 64'd6);
    localparam logic [63:0] RA_R =
        ONE_Q32 - RA_T1 + RA_T2 - RA_T3 + RA_T4 - RA_T5 + RA_T6;
    localparam logic [63:0] RA_C = (64'd5204 * 64'd65536 + 64'd100 / 64'd2) / 64'd100;

    // right fit, second exponential: 18.16 * exp(-0.0003931 x)
    localparam logic [63:0] RB_NUM = 64'd3931;
    localparam logic [63:0] RB_DEN = 64'd10000000;
    localparam logic [63:0] RB_T1 = (ONE_Q32 * RB_NUM) / (RB_DEN * 64'd1);
    localparam logic [63:0] RB_T2 = (RB_T1 * RB_NUM) / (RB_DEN * 64'd2);
    localparam logic [63:0] RB_T3 = (RB_T2 * RB_NUM) / (RB_DEN * 64'd3);
    localparam logic [63:0] RB_T4 = (RB_T3 * RB_NUM) / (RB_DEN * 64'd4);
    localparam logic [63:0] RB_T5 = (RB_T4 * RB_NUM) / (RB_DEN * 64'd5);
    localparam logic [63:0] RB_T6 = (RB_T5 * RB_NUM) / (RB_DEN * 64'd6);
    localparam logic [63:0] RB_R =
        ONE_Q32 - RB_T1 + RB_T2 - RB_T3 + RB_T4 - RB_T5 + RB_T6;
    localparam logic [63:0] RB_C = (64'd1816 * 64'd65536 + 64'd100 / 64'd2) / 64'd100;

    localparam logic [COEF_W-1:0]  LEFT_A_COEF   = LA_C[COEF_W-1:0];
    localparam logic [RATIO_W-1:0] LEFT_A_RATIO  = LA_R[RATIO_W-1:0];
    localparam logic [COEF_W-1:0]  LEFT_B_COEF   = LB_C[COEF_W-1:0];
    localparam logic [RATIO_W-1:0] LEFT_B_RATIO  = LB_R[RATIO_W-1:0];
    localparam logic [COEF_W-1:0]  RIGHT_A_COEF  = RA_C[COEF_W-1:0];
    localparam logic [RATIO_W-1:0] RIGHT_A_RATIO = RA_R[RATIO_W-1:0];
    localparam logic [COEF_W-1:0]  RIGHT_B_COEF  = RB_C[COEF_W-1:0];
    localparam logic [RATIO_W-1:0] RIGHT_B_RATIO = RB_R[RATIO_W-1:0];

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [STEER_W-1:0] center;
        logic [STEER_W-1:0] low_limit;
        logic [STEER_W-1:0] high_limit;
        logic [DIST_W-1:0]  dist_floor;
        logic [DIST_W-1:0]  dist_ceiling;
    } cfg_t;

endpackage

FILE: rtl/core/dpsc_ram.sv
// ----------------------------------------------------------------------------
// dpsc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dpsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/dpsc_tablegen.sv
// ----------------------------------------------------------------------------
// dpsc_tablegen
// Builds both calibration tables after reset, one entry per cycle, by
// stepping the powers of each exponential fit and summing the scaled terms.
// ----------------------------------------------------------------------------
module dpsc_tablegen import dpsc_pkg::*; #(
    parameter int READING_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    output logic                    done,
    output logic                    we,
    output logic [READING_BITS-1:0] waddr,
    output logic [DIST_W-1:0]       left_data,
    output logic [DIST_W-1:0]       right_data
);

    localparam int PROD_W = COEF_W + POW_W;
    localparam int STEP_W = POW_W + RATIO_W;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << 39;

    function automatic logic [TERM_W-1:0] fit_term(
        input logic [COEF_W-1:0] c,
        input logic [POW_W-1:0]  p
    );
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(c) * PROD_W'(p) + HALF;
        return prod[40 +: TERM_W];
    endfunction

    function automatic logic [POW_W-1:0] pow_step(
        input logic [POW_W-1:0]   p,
        input logic [RATIO_W-1:0] r
    );
        logic [STEP_W-1:0] prod;
        prod = STEP_W'(p) * STEP_W'(r);
        return prod[32 +: POW_W];
    endfunction

    function automatic logic [DIST_W-1:0] sat_sum(
        input logic [TERM_W-1:0] a,
        input logic [TERM_W-1:0] b
    );
        logic [TERM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > (TERM_W + 1)'({DIST_W{1'b1}}))
        begin
            return {DIST_W{1'b1}};
        end
        return s[DIST_W-1:0];
    endfunction

    logic                    run_reg, run_next;
    logic                    done_reg, done_next;
    logic [READING_BITS-1:0] x_reg, x_next;
    logic [POW_W-1:0]        pla_reg, pla_next;
    logic [POW_W-1:0]        plb_reg, plb_next;
    logic [POW_W-1:0]        pra_reg, pra_next;
    logic [POW_W-1:0]        prb_reg, prb_next;
    logic                    wv_reg, wv_next;
    logic [READING_BITS-1:0] waddr_reg;
    logic [TERM_W-1:0]       tla_reg, tlb_reg, tra_reg, trb_reg;

    always_comb
    begin
        run_next  = run_reg;
        x_next    = x_reg;
        pla_next  = pla_reg;
        plb_next  = plb_reg;
        pra_next  = pra_reg;
        prb_next  = prb_reg;
        wv_next   = 1'b0;
        done_next = done_reg;
        if (run_reg)
        begin
            wv_next  = 1'b1;
            x_next   = x_reg + 1'b1;
            pla_next = pow_step(pla_reg, LEFT_A_RATIO);
            plb_next = pow_step(plb_reg, LEFT_B_RATIO);
            pra_next = pow_step(pra_reg, RIGHT_A_RATIO);
            prb_next = pow_step(prb_reg, RIGHT_B_RATIO);
            if (x_reg == {READING_BITS{1'b1}})
            begin
                run_next = 1'b0;
            end
        end
        if (wv_reg && (waddr_reg == {READING_BITS{1'b1}}))
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            x_reg    <= '0;
            pla_reg  <= POW_ONE;
            plb_reg  <= POW_ONE;
            pra_reg  <= POW_ONE;
            prb_reg  <= POW_ONE;
            wv_reg   <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            x_reg    <= x_next;
            pla_reg  <= pla_next;
            plb_reg  <= plb_next;
            pra_reg  <= pra_next;
            prb_reg  <= prb_next;
            wv_reg   <= wv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg <= x_reg;
        tla_reg   <= fit_term(LEFT_A_COEF, pla_reg);
        tlb_reg   <= fit_term(LEFT_B_COEF, plb_reg);
        tra_reg   <= fit_term(RIGHT_A_COEF, pra_reg);
        trb_reg   <= fit_term(RIGHT_B_COEF, prb_reg);
    end

    assign done       = done_reg;
    assign we         = wv_reg;
    assign waddr      = waddr_reg;
    assign left_data  = sat_sum(tla_reg, tlb_reg);
    assign right_data = sat_sum(tra_reg, trb_reg);

endmodule

FILE: rtl/core/dpsc_front.sv
// ----------------------------------------------------------------------------
// dpsc_front
// Front end: looks up both readings in the calibration tables, limits the
// distances and works out the limited steering command for each word.
// ----------------------------------------------------------------------------
module dpsc_front import dpsc_pkg::*; #(
    parameter int READING_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    tbl_we,
    input  logic [READING_BITS-1:0] tbl_addr,
    input  logic [DIST_W-1:0]       tbl_left,
    input  logic [DIST_W-1:0]       tbl_right,
    input  logic                    in_fire,
    input  logic [READING_W-1:0]    left_reading,
    input  logic [READING_W-1:0]    right_reading,
    output logic                    push,
    output logic [STEER_W-1:0]      push_steer
);

    localparam int DEPTH  = 1 << READING_BITS;
    localparam int EXT_W  = (READING_BITS > READING_W) ? READING_BITS : READING_W;
    localparam int DIFF_W = DIST_W + 1;
    localparam int PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int QUOT_W = PROD_W - 8;
    localparam int SUM_W  = QUOT_W + 1;

    function automatic logic [DIST_W-1:0] limit_dist(
        input logic [DIST_W-1:0] d,
        input logic [DIST_W-1:0] lo,
        input logic [DIST_W-1:0] hi
    );
        if (d <= lo)
        begin
            return lo;
        end
        if (d >= hi)
        begin
            return hi;
        end
        return d;
    endfunction

    logic [EXT_W-1:0]         left_ext, right_ext;
    logic [DIST_W-1:0]        left_raw, right_raw;
    logic [DIST_W-1:0]        left_lim, right_lim;
    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [QUOT_W-1:0] quot;
    logic signed [SUM_W-1:0]  steer_sum, low_s, high_s;

    assign left_ext  = EXT_W'(left_reading);
    assign right_ext = EXT_W'(right_reading);

    dpsc_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_left_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_addr),
        .wdata (tbl_left),
        .raddr (left_ext[READING_BITS-1:0]),
        .rdata (left_raw)
    );

    dpsc_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_right_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_addr),
        .wdata (tbl_right),
        .raddr (right_ext[READING_BITS-1:0]),
        .rdata (right_raw)
    );

    assign left_lim  = limit_dist(left_raw, cfg.dist_floor, cfg.dist_ceiling);
    assign right_lim = limit_dist(right_raw, cfg.dist_floor, cfg.dist_ceiling);
    assign diff_next = $signed({1'b0, left_lim}) - $signed({1'b0, right_lim});
    assign prod_next = $signed({1'b0, cfg.gain}) * diff_reg;

    // division by 256 rounding toward zero
    assign prod_adj  = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    assign quot      = $signed(prod_adj[PROD_W-1:8]);
    assign steer_sum = $signed({{(SUM_W-STEER_W){1'b0}}, cfg.center})
                     + $signed({quot[QUOT_W-1], quot});
    assign low_s     = $signed({{(SUM_W-STEER_W){1'b0}}, cfg.low_limit});
    assign high_s    = $signed({{(SUM_W-STEER_W){1'b0}}, cfg.high_limit});

    always_comb
    begin
        if (steer_sum > high_s)
        begin
            push_steer = cfg.high_limit;
        end
        else if (steer_sum < low_s)
        begin
            push_steer = cfg.low_limit;
        end
        else
        begin
            push_steer = steer_sum[STEER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        prod_reg <= prod_next;
    end

    assign push = v3_reg;

endmodule

FILE: rtl/core/dpsc_queue.sv
// ----------------------------------------------------------------------------
// dpsc_queue
// Short register queue of steering commands between front and back ends.
// ----------------------------------------------------------------------------
module dpsc_queue #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/dpsc_back.sv
// ----------------------------------------------------------------------------
// dpsc_back
// Back end: turns each queued steering command into a six-word command
// frame, one word per cycle unless out_ready stalls, via an output register.
// ----------------------------------------------------------------------------
module dpsc_back import dpsc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  logic [STEER_W-1:0] q_steer,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  frame_byte,
    output logic               frame_last
);

    localparam logic [2:0] POS_SYNC = 3'd0;
    localparam logic [2:0] POS_LEN  = 3'd1;
    localparam logic [2:0] POS_CMD  = 3'd2;
    localparam logic [2:0] POS_LO   = 3'd3;
    localparam logic [2:0] POS_HI   = 3'd4;
    localparam logic [2:0] POS_SUM  = 3'd5;

    logic [2:0]        pos_reg, pos_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              load;
    logic [BYTE_W-1:0] lo_byte, hi_byte, sum_byte, byte_sel;

    assign lo_byte  = q_steer[7:0];
    assign hi_byte  = BYTE_W'(q_steer[STEER_W-1:8]);
    assign sum_byte = FRAME_SYNC + FRAME_LEN + FRAME_CMD + lo_byte + hi_byte;

    always_comb
    begin
        case (pos_reg)
            POS_SYNC: byte_sel = FRAME_SYNC;
            POS_LEN:  byte_sel = FRAME_LEN;
            POS_CMD:  byte_sel = FRAME_CMD;
            POS_LO:   byte_sel = lo_byte;
            POS_HI:   byte_sel = hi_byte;
            POS_SUM:  byte_sel = sum_byte;
            default:  byte_sel = FRAME_SYNC;
        endcase
    end

    assign load = q_valid && (!valid_reg || out_ready);
    assign pop  = load && (pos_reg == POS_SUM);

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            pos_next   = (pos_reg == POS_SUM) ? POS_SYNC : pos_reg + 3'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_SYNC;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_sel;
            last_reg <= (pos_reg == POS_SUM);
        end
    end

    assign out_valid  = valid_reg;
    assign frame_byte = byte_reg;
    assign frame_last = last_reg;

endmodule

FILE: rtl/core/distance_pair_steering_control.sv
// ----------------------------------------------------------------------------
// distance_pair_steering_control
// Steering command generator for a pair of distance sensors with
// calibration tables, distance limits, proportional steering and framing.
// ----------------------------------------------------------------------------
// After reset the block builds its two calibration tables, one entry per
// cycle; no reading pair is taken until then, though register writes are.
// Afterwards each accepted pair yields one six-word frame (sync, length,
// command, steering low, steering high, checksum) with frame_last on the
// checksum. In the front end the table read, the limit and difference and
// the gain multiply are registered in turn; the steering limit then feeds a
// four-entry queue. The frame serialiser sends one word per cycle while the
// receiver is ready, so a steady stream of pairs runs at one pair per frame;
// the queue lets new pairs be taken while a frame is still going out.
module distance_pair_steering_control import dpsc_pkg::*; #(
    parameter int READING_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [READING_W-1:0] left_reading,
    input  logic [READING_W-1:0] right_reading,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    frame_byte,
    output logic                 frame_last
);

    localparam logic [2:0] REG_GAIN     = 3'd0;
    localparam logic [2:0] REG_CENTER   = 3'd1;
    localparam logic [2:0] REG_LOW      = 3'd2;
    localparam logic [2:0] REG_HIGH     = 3'd3;
    localparam logic [2:0] REG_FLOOR    = 3'd4;
    localparam logic [2:0] REG_CEILING  = 3'd5;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    cfg_t                    cfg_reg, cfg_next;
    logic [2:0]              reg_idx;
    logic                    wr_en;
    logic                    table_done;
    logic                    tbl_we;
    logic [READING_BITS-1:0] tbl_addr;
    logic [DIST_W-1:0]       tbl_left, tbl_right;
    logic                    in_fire;
    logic                    push, pop, q_valid;
    logic [STEER_W-1:0]      push_steer, q_steer;
    logic [OCC_W-1:0]        occ_reg, occ_next;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_GAIN:    cfg_next.gain         = pwdata[GAIN_W-1:0];
                REG_CENTER:  cfg_next.center       = pwdata[STEER_W-1:0];
                REG_LOW:     cfg_next.low_limit    = pwdata[STEER_W-1:0];
                REG_HIGH:    cfg_next.high_limit   = pwdata[STEER_W-1:0];
                REG_FLOOR:   cfg_next.dist_floor   = pwdata[DIST_W-1:0];
                REG_CEILING: cfg_next.dist_ceiling = pwdata[DIST_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GAIN:    prdata = 32'(cfg_reg.gain);
            REG_CENTER:  prdata = 32'(cfg_reg.center);
            REG_LOW:     prdata = 32'(cfg_reg.low_limit);
            REG_HIGH:    prdata = 32'(cfg_reg.high_limit);
            REG_FLOOR:   prdata = 32'(cfg_reg.dist_floor);
            REG_CEILING: prdata = 32'(cfg_reg.dist_ceiling);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain         <= 8'd80;
            cfg_reg.center       <= 12'd1500;
            cfg_reg.low_limit    <= 12'd1000;
            cfg_reg.high_limit   <= 12'd2000;
            cfg_reg.dist_floor   <= 16'd1024;
            cfg_reg.dist_ceiling <= 16'd7680;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // words in flight in the front end plus those queued
    assign in_ready = table_done && (occ_reg < OCC_W'(QUEUE_DEPTH));
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_fire && !pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (pop && !in_fire)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    dpsc_tablegen #(
        .READING_BITS (READING_BITS)
    ) u_tablegen (
        .clk        (clk),
        .rst_n      (rst_n),
        .done       (table_done),
        .we         (tbl_we),
        .waddr      (tbl_addr),
        .left_data  (tbl_left),
        .right_data (tbl_right)
    );

    dpsc_front #(
        .READING_BITS (READING_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .tbl_we        (tbl_we),
        .tbl_addr      (tbl_addr),
        .tbl_left      (tbl_left),
        .tbl_right     (tbl_right),
        .in_fire       (in_fire),
        .left_reading  (left_reading),
        .right_reading (right_reading),
        .push          (push),
        .push_steer    (push_steer)
    );

    dpsc_queue #(
        .WIDTH (STEER_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_steer),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_steer)
    );

    dpsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_steer    (q_steer),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

`ifndef SYNTHESIS
    ap_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    ap_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && frame_last) |=> (!out_valid || frame_byte == FRAME_SYNC))
        else $error("frame does not restart with sync word");

    ap_frame_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !frame_last) |=> out_valid)
        else $error("gap inside a frame");

    ap_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (occ_reg != '0))
        else $error("frame finished with nothing outstanding");
`endif

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the distance pair steering controller. A local model
// of the calibration tables, distance limits and proportional steering predicts
// each six-word command frame. The frames are compared word by word with the
// block's output under random sender gaps and receiver stalls, and over several
// register settings: reset values, extremes, inverted limits and random ones.
// ----------------------------------------------------------------------------
module testbench import dpsc_pkg::*; ();

    localparam int TABLE_BITS  = 12;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    localparam bit [63:0] UNITY_Q32 = 64'd1 << 32;
    localparam bit [63:0] HALF_Q40  = 64'd1 << 39;

    localparam bit [BYTE_W-1:0] SYNC_WORD = 8'hA3;
    localparam bit [BYTE_W-1:0] LEN_WORD  = 8'h04;
    localparam bit [BYTE_W-1:0] CMD_WORD  = 8'h01;

    typedef enum int {
        REG_GAIN       = 0,
        REG_CENTER     = 1,
        REG_LOW_LIMIT  = 2,
        REG_HIGH_LIMIT = 3,
        REG_FLOOR      = 4,
        REG_CEILING    = 5,
        REG_SPARE_A    = 6,
        REG_SPARE_B    = 7
    } steer_reg_t;

    typedef struct packed {
        bit [BYTE_W-1:0] data;
        bit              last;
    } frame_word_t;

    localparam cfg_t RESET_CFG = '{gain: 8'd80, center: 12'd1500, low_limit: 12'd1000,
                                   high_limit: 12'd2000, dist_floor: 16'd1024,
                                   dist_ceiling: 16'd7680};
    localparam cfg_t FULL_CFG  = '{gain: 8'd255, center: 12'd4095, low_limit: 12'd4095,
                                   high_limit: 12'd4095, dist_floor: 16'd65535,
                                   dist_ceiling: 16'd65535};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [4:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [READING_W-1:0] left_reading = '0;
    logic [READING_W-1:0] right_reading = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BYTE_W-1:0]    frame_byte;
    logic                 frame_last;

    bit [DIST_W-1:0] cm_rom [2][TABLE_SIZE];
    cfg_t            live_cfg;
    frame_word_t     frame_due [$];

    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    int fault_count     = 0;
    int words_checked   = 0;
    int pairs_sent      = 0;
    int settings_loaded = 0;
    int cycle_count     = 0;

    distance_pair_steering_control #(
        .READING_BITS(TABLE_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_reading (left_reading),
        .right_reading(right_reading),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .frame_last   (frame_last)
    );

    always #10 clk = ~clk;

    function automatic void report_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    // exp(-num/den) in Q0.32 from the series up to its sixth-power term
    function automatic bit [63:0] decay_ratio(bit [63:0] num, bit [63:0] den);
        bit [63:0] term;
        bit [63:0] acc;
        term = UNITY_Q32;
        acc  = UNITY_Q32;
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * num) / (den * 64'(k));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    function automatic void build_cm_rom(int side,
                                         bit [63:0] a_num, bit [63:0] a_den,
                                         bit [63:0] ea_num, bit [63:0] ea_den,
                                         bit [63:0] b_num, bit [63:0] b_den,
                                         bit [63:0] eb_num, bit [63:0] eb_den);
        bit [63:0] coef_a;
        bit [63:0] coef_b;
        bit [63:0] ratio_a;
        bit [63:0] ratio_b;
        bit [63:0] pow_a;
        bit [63:0] pow_b;
        bit [63:0] sum;
        coef_a  = (a_num * 64'd65536 + a_den / 64'd2) / a_den;
        coef_b  = (b_num * 64'd65536 + b_den / 64'd2) / b_den;
        ratio_a = decay_ratio(ea_num, ea_den);
        ratio_b = decay_ratio(eb_num, eb_den);
        pow_a   = UNITY_Q32;
        pow_b   = UNITY_Q32;
        for (int x = 0; x < TABLE_SIZE; x++)
        begin
            sum = ((coef_a * pow_a + HALF_Q40) >> 40) + ((coef_b * pow_b + HALF_Q40) >> 40);
            cm_rom[side][x] = (sum > 64'd65535) ? 16'hFFFF : sum[DIST_W-1:0];
            pow_a = (pow_a * ratio_a) >> 32;
            pow_b = (pow_b * ratio_b) >> 32;
        end
    endfunction

    function automatic int clamp_cm(int d);
        if (d <= int'(live_cfg.dist_floor))
            return int'(live_cfg.dist_floor);
        if (d >= int'(live_cfg.dist_ceiling))
            return int'(live_cfg.dist_ceiling);
        return d;
    endfunction

    function automatic void predict_steer_frame(bit [READING_W-1:0] l, bit [READING_W-1:0] r);
        int              left_cm;
        int              right_cm;
        int              steer;
        bit [BYTE_W-1:0] words [6];
        bit [BYTE_W-1:0] checksum;
        left_cm  = clamp_cm(int'(cm_rom[0][int'(l) & (TABLE_SIZE - 1)]));
        right_cm = clamp_cm(int'(cm_rom[1][int'(r) & (TABLE_SIZE - 1)]));
        steer    = int'(live_cfg.center) + (int'(live_cfg.gain) * (left_cm - right_cm)) / 256;
        if (steer > int'(live_cfg.high_limit))
            steer = int'(live_cfg.high_limit);
        else if (steer < int'(live_cfg.low_limit))
            steer = int'(live_cfg.low_limit);
        words[0] = SYNC_WORD;
        words[1] = LEN_WORD;
        words[2] = CMD_WORD;
        words[3] = steer[7:0];
        words[4] = steer[15:8];
        checksum = '0;
        for (int k = 0; k < 5; k++)
            checksum = checksum + words[k];
        words[5] = checksum;
        for (int k = 0; k < 6; k++)
            frame_due.push_back('{data: words[k], last: (k == 5)});
    endfunction

    function automatic bit [31:0] pick_level(bit [31:0] top);
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    function automatic bit [31:0] with_noise(bit [31:0] v, int w);
        return (($urandom >> w) << w) | v;
    endfunction

    function automatic bit [READING_W-1:0] random_reading();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return READING_W'(1 << $urandom_range(0, READING_W - 1));
            3:       return READING_W'($urandom_range(600, 1500));
            default: return READING_W'($urandom_range(0, TABLE_SIZE - 1));
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.gain         = GAIN_W'(pick_level(255));
        s.center       = STEER_W'(pick_level(4095));
        s.low_limit    = STEER_W'(pick_level(4095));
        s.high_limit   = STEER_W'(pick_level(4095));
        s.dist_floor   = DIST_W'(pick_level(65535));
        s.dist_ceiling = DIST_W'(pick_level(65535));
        return s;
    endfunction

    // register write, then read back where the address holds a register
    task automatic write_reg(steer_reg_t idx, bit [31:0] value);
        bit [31:0] stored;
        bit [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_GAIN:       live_cfg.gain         = value[GAIN_W-1:0];
            REG_CENTER:     live_cfg.center       = value[STEER_W-1:0];
            REG_LOW_LIMIT:  live_cfg.low_limit    = value[STEER_W-1:0];
            REG_HIGH_LIMIT: live_cfg.high_limit   = value[STEER_W-1:0];
            REG_FLOOR:      live_cfg.dist_floor   = value[DIST_W-1:0];
            REG_CEILING:    live_cfg.dist_ceiling = value[DIST_W-1:0];
            default:        ;
        endcase
        case (idx)
            REG_GAIN:       stored = 32'(live_cfg.gain);
            REG_CENTER:     stored = 32'(live_cfg.center);
            REG_LOW_LIMIT:  stored = 32'(live_cfg.low_limit);
            REG_HIGH_LIMIT: stored = 32'(live_cfg.high_limit);
            REG_FLOOR:      stored = 32'(live_cfg.dist_floor);
            REG_CEILING:    stored = 32'(live_cfg.dist_ceiling);
            default:        stored = 32'd0;
        endcase
        if (idx <= REG_CEILING)
        begin
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(negedge clk);
            readback = prdata;
            @(posedge clk);
            if (readback !== stored)
                report_fault($sformatf("register %s read back %0h, expected %0h",
                                       idx.name(), readback, stored));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(cfg_t s);
        write_reg(REG_GAIN,       with_noise(32'(s.gain), GAIN_W));
        write_reg(REG_CENTER,     with_noise(32'(s.center), STEER_W));
        write_reg(REG_LOW_LIMIT,  with_noise(32'(s.low_limit), STEER_W));
        write_reg(REG_HIGH_LIMIT, with_noise(32'(s.high_limit), STEER_W));
        write_reg(REG_FLOOR,      with_noise(32'(s.dist_floor), DIST_W));
        write_reg(REG_CEILING,    with_noise(32'(s.dist_ceiling), DIST_W));
        settings_loaded++;
    endtask

    task automatic send_pair(bit [READING_W-1:0] l, bit [READING_W-1:0] r);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        left_reading  <= l;
        right_reading <= r;
        do
            @(posedge clk);
        while (!in_ready);
        predict_steer_frame(l, r);
        pairs_sent++;
    endtask

    // stop sending and let every outstanding frame word come out
    task automatic await_frames();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (frame_due.size() != 0);
    endtask

    task automatic test_default_settings();
        send_pair(12'h000, 12'h000);
        send_pair(12'hFFF, 12'hFFF);
        send_pair(12'h000, 12'hFFF);
        send_pair(12'hFFF, 12'h000);
        send_pair(12'hAAA, 12'h555);
        send_pair(12'h555, 12'hAAA);
        send_pair(12'd900, 12'd1400);
    endtask

    // full read-back at the top and the reset values, then writes to unused addresses
    task automatic test_register_map();
        await_frames();
        load_settings(FULL_CFG);
        load_settings(RESET_CFG);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        send_pair(12'd1000, 12'd1000);
        send_pair(12'd800, 12'd2000);
    endtask

    // top gain over the widest distance span
    task automatic test_wide_product();
        await_frames();
        load_settings('{gain: 8'd255, center: 12'd2048, low_limit: 12'd0,
                        high_limit: 12'd4095, dist_floor: 16'd0, dist_ceiling: 16'd65535});
        send_pair(12'd0, 12'd4095);
        send_pair(12'd4095, 12'd0);
        send_pair(12'd0, 12'd0);
        send_pair(12'd4095, 12'd4095);
        send_pair(12'd2000, 12'd2000);
        send_pair(12'd3000, 12'd1500);
        send_pair(12'd1500, 12'd3000);
        send_pair(12'd2500, 12'd4000);
    endtask

    // floor above ceiling and high limit below low limit
    task automatic test_inverted_limits();
        await_frames();
        load_settings('{gain: 8'd40, center: 12'd1500, low_limit: 12'd2000,
                        high_limit: 12'd1000, dist_floor: 16'd7680, dist_ceiling: 16'd1024});
        send_pair(12'd0, 12'd0);
        send_pair(12'd4095, 12'd4095);
        send_pair(12'd0, 12'd4095);
        send_pair(12'd4095, 12'd0);
        send_pair(12'd700, 12'd700);
        send_pair(12'd1200, 12'd2600);
        send_pair(12'd2600, 12'd1200);
        send_pair(12'hFFF, 12'h800);
    endtask

    task automatic test_random_traffic();
        cfg_t s;
        for (int phase = 0; phase < 5; phase++)
        begin
            await_frames();
            s = random_settings();
            if (phase == 1)
                s = '0;
            if (phase == 4)
            begin
                s.gain         = 8'd255;
                s.dist_floor   = 16'd0;
                s.dist_ceiling = 16'd65535;
            end
            load_settings(s);
            sender_steady   = (phase == 0);
            receiver_steady = (phase == 0) || (phase == 3);
            for (int n = 0; n < 47; n++)
            begin
                if (phase == 2 && n == 23)
                    await_frames();
                if ($urandom_range(0, 19) == 0)
                    sender_steady = !sender_steady;
                if ($urandom_range(0, 19) == 0)
                    receiver_steady = !receiver_steady;
                send_pair(random_reading(), random_reading());
            end
        end
    endtask

    // frame receiver with random back-pressure
    initial
    begin : frame_sink
        int hold;
        @(posedge clk);
        forever
        begin
            hold = receiver_steady ? 0 : $urandom_range(0, 9);
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin : word_check
        frame_word_t due;
        if (out_valid && out_ready)
        begin
            if (frame_due.size() == 0)
                report_fault($sformatf("frame word %02h last %0b with nothing due",
                                       frame_byte, frame_last));
            else
            begin
                due = frame_due.pop_front();
                if (frame_byte !== due.data)
                    report_fault($sformatf("word %0d byte expected %02h got %02h",
                                           words_checked, due.data, frame_byte));
                if (frame_last !== due.last)
                    report_fault($sformatf("word %0d last expected %0b got %0b",
                                           words_checked, due.last, frame_last));
            end
            words_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d frame words outstanding",
                     cycle_count, frame_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        live_cfg = RESET_CFG;
        build_cm_rom(0, 64'd6386, 64'd10, 64'd4488, 64'd1000000,
                     64'd2645, 64'd100, 64'd508, 64'd1000000);
        build_cm_rom(1, 64'd5204, 64'd100, 64'd1964, 64'd1000000,
                     64'd1816, 64'd100, 64'd3931, 64'd10000000);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_settings();
        test_register_map();
        test_wide_product();
        test_inverted_limits();
        test_random_traffic();
        await_frames();
        repeat (12) @(posedge clk);
        $display("covered %0d reading pairs and %0d frame words over %0d register settings",
                 pairs_sent, words_checked, settings_loaded);
        $display("including extremes, inverted limits and random stalls; %0d mismatches",
                 fault_count);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
